// ===== sv/hrhl_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhl_pkg
// Shared types, codes and character classes for the request head lexer.
// ----------------------------------------------------------------------------
package hrhl_pkg;

   localparam int DataWidth  = 8;
   localparam int StateWidth = 4;
   localparam int KindWidth  = 3;
   localparam int PosWidth   = 4;

   localparam logic [StateWidth-1:0] ST_METHOD   = 4'd0;
   localparam logic [StateWidth-1:0] ST_PATH     = 4'd1;
   localparam logic [StateWidth-1:0] ST_VERSION  = 4'd2;
   localparam logic [StateWidth-1:0] ST_REQ_CR   = 4'd3;
   localparam logic [StateWidth-1:0] ST_REQ_LF   = 4'd4;
   localparam logic [StateWidth-1:0] ST_HNAME    = 4'd5;
   localparam logic [StateWidth-1:0] ST_HVALUE   = 4'd6;
   localparam logic [StateWidth-1:0] ST_HDR_CR   = 4'd7;
   localparam logic [StateWidth-1:0] ST_HDR_LF   = 4'd8;
   localparam logic [StateWidth-1:0] ST_BLANK_CR = 4'd9;
   localparam logic [StateWidth-1:0] ST_BODY     = 4'd10;

   localparam logic [KindWidth-1:0] KIND_METHOD = 3'd0;
   localparam logic [KindWidth-1:0] KIND_PATH   = 3'd1;
   localparam logic [KindWidth-1:0] KIND_VERSION = 3'd2;
   localparam logic [KindWidth-1:0] KIND_HNAME  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_HVALUE = 3'd4;
   localparam logic [KindWidth-1:0] KIND_BODY   = 3'd5;
   localparam logic [KindWidth-1:0] KIND_DELIM  = 3'd6;

   localparam logic [DataWidth-1:0] CH_SP    = 8'h20;
   localparam logic [DataWidth-1:0] CH_CR    = 8'h0D;
   localparam logic [DataWidth-1:0] CH_LF    = 8'h0A;
   localparam logic [DataWidth-1:0] CH_COLON = 8'h3A;
   localparam logic [DataWidth-1:0] CH_SLASH = 8'h2F;
   localparam logic [DataWidth-1:0] CH_QUEST = 8'h3F;
   localparam logic [DataWidth-1:0] CH_DASH  = 8'h2D;
   localparam logic [DataWidth-1:0] CH_DOT   = 8'h2E;
   localparam logic [DataWidth-1:0] CH_H     = 8'h48;
   localparam logic [DataWidth-1:0] CH_T     = 8'h54;
   localparam logic [DataWidth-1:0] CH_P     = 8'h50;

   localparam logic [PosWidth-1:0] VERSION_LEN = 4'd8;

   typedef struct packed {
      logic [DataWidth-1:0] data_byte;
      logic                 first_of_message;
   } req_word_type;

   typedef struct packed {
      logic [DataWidth-1:0]  byte_out;
      logic [KindWidth-1:0]  field_kind;
      logic                  field_done;
      logic                  parse_error;
      logic [StateWidth-1:0] failed_state;
   } rsp_word_type;

   typedef struct packed {
      logic [StateWidth-1:0] parse_state;
      logic [PosWidth-1:0]   version_position;
      logic                  error_flag;
      logic [StateWidth-1:0] error_state;
   } lex_state_type;

   function automatic logic [KindWidth-1:0] state_kind(input logic [StateWidth-1:0] st);
      logic [KindWidth-1:0] k;
      case (st)
         ST_METHOD:  k = KIND_METHOD;
         ST_PATH:    k = KIND_PATH;
         ST_VERSION: k = KIND_VERSION;
         ST_HNAME:   k = KIND_HNAME;
         ST_HVALUE:  k = KIND_HVALUE;
         ST_BODY:    k = KIND_BODY;
         default:    k = KIND_DELIM;
      endcase
      return k;
   endfunction

   function automatic logic is_alpha(input logic [DataWidth-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [DataWidth-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_path_char(input logic [DataWidth-1:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_SLASH || c == CH_QUEST || c == CH_DASH;
   endfunction

   function automatic logic is_name_char(input logic [DataWidth-1:0] c);
      return is_alpha(c) || c == CH_DASH;
   endfunction

   function automatic logic is_value_char(input logic [DataWidth-1:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_DASH || c == CH_SP ||
             c == CH_DOT || c == CH_COLON;
   endfunction

   function automatic logic version_char_ok(input logic [PosWidth-1:0] pos,
                                            input logic [DataWidth-1:0] c);
      logic ok;
      case (pos)
         4'd0:    ok = (c == CH_H);
         4'd1:    ok = (c == CH_T);
         4'd2:    ok = (c == CH_T);
         4'd3:    ok = (c == CH_P);
         4'd4:    ok = (c == CH_SLASH);
         4'd5:    ok = is_digit(c);
         4'd6:    ok = (c == CH_DOT);
         4'd7:    ok = is_digit(c);
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ===== sv/hrhl_req_if.sv =====
// ----------------------------------------------------------------------------
// hrhl_req_if
// Request byte channel: valid, ready and one byte word.
// ----------------------------------------------------------------------------
interface hrhl_req_if
   import hrhl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] data_byte;
   logic                 first_of_message;

   modport source (output valid, output data_byte, output first_of_message, input ready);
   modport sink   (input valid, input data_byte, input first_of_message, output ready);
endinterface

// ===== sv/hrhl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hrhl_rsp_if
// Result channel: valid, ready and one tagged byte word.
// ----------------------------------------------------------------------------
interface hrhl_rsp_if
   import hrhl_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [DataWidth-1:0]  byte_out;
   logic [KindWidth-1:0]  field_kind;
   logic                  field_done;
   logic                  parse_error;
   logic [StateWidth-1:0] failed_state;

   modport source (output valid, output byte_out, output field_kind, output field_done,
                   output parse_error, output failed_state, input ready);
   modport sink   (input valid, input byte_out, input field_kind, input field_done,
                   input parse_error, input failed_state, output ready);
endinterface

// ===== sv/hrhl_input_stage.sv =====
// ----------------------------------------------------------------------------
// hrhl_input_stage
// Input register for request bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module hrhl_input_stage
   import hrhl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   hrhl_req_if.sink      req_chan,
   input  logic          take,
   output logic          word_valid,
   output req_word_type  word
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff.data_byte        <= req_chan.data_byte;
         word_ff.first_of_message <= req_chan.first_of_message;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// ===== sv/hrhl_lexer_core.sv =====
// ----------------------------------------------------------------------------
// hrhl_lexer_core
// Parser state registers and the per-byte transition and tagging logic.
// ----------------------------------------------------------------------------
module hrhl_lexer_core
   import hrhl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_word_type  word,
   output rsp_word_type  result
);

   lex_state_type state_ff;
   lex_state_type state_in;
   lex_state_type cur;
   logic [KindWidth-1:0] kind;
   logic                 done;
   logic                 ok;
   logic [StateWidth-1:0] next_st;
   logic [DataWidth-1:0]  c;

   localparam lex_state_type LexReset = '{
      parse_state:      ST_METHOD,
      version_position: '0,
      error_flag:       1'b0,
      error_state:      '0
   };

   assign c = word.data_byte;

   always_comb begin
      cur      = word.first_of_message ? LexReset : state_ff;
      state_in = cur;
      next_st  = cur.parse_state;
      kind     = state_kind(cur.parse_state);
      done     = 1'b0;
      ok       = 1'b1;
      if (!cur.error_flag) begin
         unique case (cur.parse_state)
            ST_METHOD: begin
               if (is_alpha(c)) begin
                  kind = KIND_METHOD;
               end else if (c == CH_SP) begin
                  kind = KIND_DELIM; done = 1'b1; next_st = ST_PATH;
               end else begin
                  ok = 1'b0;
               end
            end
            ST_PATH: begin
               if (is_path_char(c)) begin
                  kind = KIND_PATH;
               end else if (c == CH_SP) begin
                  kind = KIND_DELIM; done = 1'b1; next_st = ST_VERSION;
                  state_in.version_position = '0;
               end else begin
                  ok = 1'b0;
               end
            end
            ST_VERSION: begin
               if (c == CH_CR && cur.version_position >= VERSION_LEN) begin
                  kind = KIND_DELIM; done = 1'b1; next_st = ST_REQ_CR;
               end else if (version_char_ok(cur.version_position, c)) begin
                  kind = KIND_VERSION;
                  state_in.version_position = cur.version_position + PosWidth'(1);
               end else begin
                  ok = 1'b0;
               end
            end
            ST_REQ_CR, ST_HDR_CR: begin
               if (c == CH_LF) begin
                  kind    = KIND_DELIM;
                  next_st = (cur.parse_state == ST_REQ_CR) ? ST_REQ_LF : ST_HDR_LF;
               end else begin
                  ok = 1'b0;
               end
            end
            ST_REQ_LF: begin
               if (is_name_char(c)) begin
                  kind = KIND_HNAME; next_st = ST_HNAME;
               end else begin
                  ok = 1'b0;
               end
            end
            ST_HNAME: begin
               if (is_name_char(c)) begin
                  kind = KIND_HNAME;
               end else if (c == CH_COLON) begin
                  kind = KIND_DELIM; done = 1'b1; next_st = ST_HVALUE;
               end else begin
                  ok = 1'b0;
               end
            end
            ST_HVALUE: begin
               if (is_value_char(c)) begin
                  kind = KIND_HVALUE;
               end else if (c == CH_CR) begin
                  kind = KIND_DELIM; done = 1'b1; next_st = ST_HDR_CR;
               end else begin
                  ok = 1'b0;
               end
            end
            ST_HDR_LF: begin
               if (is_name_char(c)) begin
                  kind = KIND_HNAME; next_st = ST_HNAME;
               end else if (c == CH_CR) begin
                  kind = KIND_DELIM; next_st = ST_BLANK_CR;
               end else begin
                  ok = 1'b0;
               end
            end
            ST_BLANK_CR: begin
               if (c == CH_LF) begin
                  kind = KIND_DELIM; next_st = ST_BODY;
               end else begin
                  ok = 1'b0;
               end
            end
            ST_BODY: begin
               kind = KIND_BODY;
            end
            default: begin
               ok = 1'b0;
            end
         endcase
         if (!ok) begin
            state_in.error_flag  = 1'b1;
            state_in.error_state = cur.parse_state;
            kind                 = state_kind(cur.parse_state);
            done                 = 1'b0;
         end else begin
            state_in.parse_state = next_st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LexReset;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   assign result.byte_out     = c;
   assign result.field_kind   = kind;
   assign result.field_done   = done;
   assign result.parse_error  = state_in.error_flag;
   assign result.failed_state = state_in.error_state;

endmodule

// ===== sv/hrhl_result_stage.sv =====
// ----------------------------------------------------------------------------
// hrhl_result_stage
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module hrhl_result_stage
   import hrhl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   hrhl_rsp_if.source    rsp_chan,
   input  logic          load,
   input  rsp_word_type  result,
   output logic          has_room
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign has_room = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.byte_out     = word_ff.byte_out;
   assign rsp_chan.field_kind   = word_ff.field_kind;
   assign rsp_chan.field_done   = word_ff.field_done;
   assign rsp_chan.parse_error  = word_ff.parse_error;
   assign rsp_chan.failed_state = word_ff.failed_state;

endmodule

// ===== sv/http_request_head_lexer.sv =====
// an accepted word is held in the input register, then loaded into the result register
// throughput: one byte per cycle unless stalled, set by the single state update per byte
// the result register frees while the input register refills, so stalls cost nothing extra
// synchronous reset empties both registers and returns the parser to the method field
// ----------------------------------------------------------------------------
// http_request_head_lexer
// Streaming lexer for the head of a request: tags each byte with its field.
// ----------------------------------------------------------------------------
module http_request_head_lexer
   import hrhl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hrhl_req_if.sink   req_chan,
   hrhl_rsp_if.source rsp_chan
);

   logic         word_valid;
   req_word_type word;
   rsp_word_type result;
   logic         has_room;
   logic         step;

   assign step = word_valid && has_room;

   hrhl_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (step),
      .word_valid (word_valid),
      .word       (word)
   );

   hrhl_lexer_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (word),
      .result (result)
   );

   hrhl_result_stage u_result (
      .clock    (clock),
      .reset    (reset),
      .rsp_chan (rsp_chan),
      .load     (step),
      .result   (result),
      .has_room (has_room)
   );

endmodule

// ===== tb/tb_hrhl_tag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hrhl_tag_checker
// Watches the byte and tag channels of the request head lexer, tags each
// accepted byte with its own lexer state machine and compares every tag
// word returned by the block, field by field, in order.
// ----------------------------------------------------------------------------
module tb_hrhl_tag_checker
   import hrhl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hrhl_req_if  req_mon,
   hrhl_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   rsp_word_type          expected_tags[$];
   int                    error_total = 0;
   logic [StateWidth-1:0] lex_state;
   logic [PosWidth-1:0]   ver_pos;
   logic                  lex_err;
   logic [StateWidth-1:0] lex_err_state;

   function automatic logic char_alpha(input logic [DataWidth-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic char_num(input logic [DataWidth-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic char_hname(input logic [DataWidth-1:0] c);
      return c == CH_DASH || char_alpha(c);
   endfunction

   function automatic logic char_target(input logic [DataWidth-1:0] c);
      return char_hname(c) || char_num(c) || c == CH_SLASH || c == CH_QUEST;
   endfunction

   function automatic logic char_hvalue(input logic [DataWidth-1:0] c);
      return char_hname(c) || char_num(c) || c == CH_SP || c == CH_DOT || c == CH_COLON;
   endfunction

   function automatic logic ver_char_fits(input logic [PosWidth-1:0] pos,
                                          input logic [DataWidth-1:0] c);
      logic fits;
      fits = 1'b0;
      case (pos)
         4'd0: fits = c == CH_H;
         4'd1, 4'd2: fits = c == CH_T;
         4'd3: fits = c == CH_P;
         4'd4: fits = c == CH_SLASH;
         4'd5, 4'd7: fits = char_num(c);
         4'd6: fits = c == CH_DOT;
         default: fits = 1'b0;
      endcase
      return fits;
   endfunction

   function automatic logic [KindWidth-1:0] kind_of(input logic [StateWidth-1:0] st);
      logic [KindWidth-1:0] k;
      k = KIND_DELIM;
      if (st == ST_METHOD) k = KIND_METHOD;
      else if (st == ST_PATH) k = KIND_PATH;
      else if (st == ST_VERSION) k = KIND_VERSION;
      else if (st == ST_HNAME) k = KIND_HNAME;
      else if (st == ST_HVALUE) k = KIND_HVALUE;
      else if (st == ST_BODY) k = KIND_BODY;
      return k;
   endfunction

   function automatic void restart_lexer();
      lex_state     = ST_METHOD;
      ver_pos       = '0;
      lex_err       = 1'b0;
      lex_err_state = '0;
   endfunction

   function automatic rsp_word_type tag_byte(input logic [DataWidth-1:0] c,
                                             input logic first);
      rsp_word_type          r;
      logic [StateWidth-1:0] nxt;
      logic                  legal;
      if (first) restart_lexer();
      nxt          = lex_state;
      legal        = 1'b1;
      r.byte_out   = c;
      r.field_kind = kind_of(lex_state);
      r.field_done = 1'b0;
      if (!lex_err) begin
         case (lex_state)
            ST_METHOD: begin
               if (char_alpha(c)) r.field_kind = KIND_METHOD;
               else if (c == CH_SP) begin
                  r.field_kind = KIND_DELIM;
                  r.field_done = 1'b1;
                  nxt          = ST_PATH;
               end else legal = 1'b0;
            end
            ST_PATH: begin
               if (char_target(c)) r.field_kind = KIND_PATH;
               else if (c == CH_SP) begin
                  r.field_kind = KIND_DELIM;
                  r.field_done = 1'b1;
                  nxt          = ST_VERSION;
                  ver_pos      = '0;
               end else legal = 1'b0;
            end
            ST_VERSION: begin
               if (c == CH_CR && ver_pos >= VERSION_LEN) begin
                  r.field_kind = KIND_DELIM;
                  r.field_done = 1'b1;
                  nxt          = ST_REQ_CR;
               end else if (ver_char_fits(ver_pos, c)) begin
                  r.field_kind = KIND_VERSION;
                  ver_pos      = ver_pos + PosWidth'(1);
               end else legal = 1'b0;
            end
            ST_REQ_CR, ST_HDR_CR: begin
               if (c == CH_LF) begin
                  r.field_kind = KIND_DELIM;
                  nxt          = (lex_state == ST_REQ_CR) ? ST_REQ_LF : ST_HDR_LF;
               end else legal = 1'b0;
            end
            ST_REQ_LF: begin
               if (char_hname(c)) begin
                  r.field_kind = KIND_HNAME;
                  nxt          = ST_HNAME;
               end else legal = 1'b0;
            end
            ST_HNAME: begin
               if (char_hname(c)) r.field_kind = KIND_HNAME;
               else if (c == CH_COLON) begin
                  r.field_kind = KIND_DELIM;
                  r.field_done = 1'b1;
                  nxt          = ST_HVALUE;
               end else legal = 1'b0;
            end
            ST_HVALUE: begin
               if (char_hvalue(c)) r.field_kind = KIND_HVALUE;
               else if (c == CH_CR) begin
                  r.field_kind = KIND_DELIM;
                  r.field_done = 1'b1;
                  nxt          = ST_HDR_CR;
               end else legal = 1'b0;
            end
            ST_HDR_LF: begin
               if (char_hname(c)) begin
                  r.field_kind = KIND_HNAME;
                  nxt          = ST_HNAME;
               end else if (c == CH_CR) begin
                  r.field_kind = KIND_DELIM;
                  nxt          = ST_BLANK_CR;
               end else legal = 1'b0;
            end
            ST_BLANK_CR: begin
               if (c == CH_LF) begin
                  r.field_kind = KIND_DELIM;
                  nxt          = ST_BODY;
               end else legal = 1'b0;
            end
            ST_BODY: r.field_kind = KIND_BODY;
            default: legal = 1'b0;
         endcase
         if (!legal) begin
            // first bad byte freezes the lexer until the next message start
            lex_err       = 1'b1;
            lex_err_state = lex_state;
            r.field_kind  = kind_of(lex_state);
            r.field_done  = 1'b0;
         end else lex_state = nxt;
      end
      r.parse_error  = lex_err;
      r.failed_state = lex_err_state;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         restart_lexer();
         expected_tags.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_tags.push_back(tag_byte(req_mon.data_byte, req_mon.first_of_message));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.byte_out     = rsp_mon.byte_out;
            got.field_kind   = rsp_mon.field_kind;
            got.field_done   = rsp_mon.field_done;
            got.parse_error  = rsp_mon.parse_error;
            got.failed_state = rsp_mon.failed_state;
            if (expected_tags.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: unexpected tag word byte=%h kind=%0d done=%b err=%b st=%0d",
                           $realtime, got.byte_out, got.field_kind, got.field_done,
                           got.parse_error, got.failed_state);
            end else begin
               want = expected_tags.pop_front();
               if (got.byte_out !== want.byte_out || got.field_kind !== want.field_kind ||
                   got.field_done !== want.field_done ||
                   got.parse_error !== want.parse_error ||
                   got.failed_state !== want.failed_state) begin
                  error_total++;
                  if (error_total <= 10)
                     $display("%0t: tag mismatch exp %h/%0d/%b/%b/%0d got %h/%0d/%b/%b/%0d",
                              $realtime, want.byte_out, want.field_kind, want.field_done,
                              want.parse_error, want.failed_state, got.byte_out,
                              got.field_kind, got.field_done, got.parse_error,
                              got.failed_state);
               end
            end
         end
      end
      pending_count <= expected_tags.size();
      fail_count    <= error_total;
   end

endmodule

// ===== tb/tb_http_request_head_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_head_lexer
// Feeds the request head lexer a few hand-built requests, then random
// requests, most well formed and some damaged or pure noise, under three phases
// of sender/receiver stalls, none in the last; the checker scores every tag word.
// ----------------------------------------------------------------------------
module tb_http_request_head_lexer;
   import hrhl_pkg::*;

   localparam int WordTarget = 950;
   localparam int StallLimit = 2000;

   typedef enum int {
      FLAW_NONE,
      FLAW_SWAP_BYTE,
      FLAW_DROP_BYTE,
      FLAW_NO_HEADER,
      FLAW_SHORT_VERSION,
      FLAW_NOISE
   } flaw_type;

   logic                 clock = 1'b0;
   logic                 reset;
   int                   fail_count;
   int                   pending_count;
   int                   words_sent;
   int                   tx_idle_pct;
   int                   rx_idle_pct;
   int                   quiet_cycles;
   logic [DataWidth-1:0] msg_bytes[$];

   hrhl_req_if req_chan();
   hrhl_rsp_if rsp_chan();

   http_request_head_lexer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tb_hrhl_tag_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("tb_http_request_head_lexer failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [DataWidth-1:0] pick_char(input string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   task automatic send_word(input logic [DataWidth-1:0] b, input logic first);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.data_byte        <= b;
      req_chan.first_of_message <= first;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_message(input logic lead_first, input logic stray_starts);
      foreach (msg_bytes[i])
         send_word(msg_bytes[i], (i == 0) ? lead_first
                                          : (stray_starts && $urandom_range(63) == 0));
   endtask

   task automatic compose_request(input int n_headers, input int ver_len);
      string alpha_set;
      string version_text;
      alpha_set    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
      version_text = $sformatf("HTTP/%0d.%0d", $urandom_range(9), $urandom_range(9));
      msg_bytes.delete();
      repeat ($urandom_range(5)) msg_bytes.push_back(pick_char(alpha_set));
      msg_bytes.push_back(CH_SP);
      repeat ($urandom_range(6)) msg_bytes.push_back(pick_char({alpha_set, "0123456789/?-"}));
      msg_bytes.push_back(CH_SP);
      for (int i = 0; i < ver_len; i++) msg_bytes.push_back(version_text[i]);
      msg_bytes.push_back(CH_CR);
      msg_bytes.push_back(CH_LF);
      repeat (n_headers) begin
         repeat ($urandom_range(3) + 1) msg_bytes.push_back(pick_char({alpha_set, "-"}));
         msg_bytes.push_back(CH_COLON);
         repeat ($urandom_range(5))
            msg_bytes.push_back(pick_char({alpha_set, "0123456789-.: "}));
         msg_bytes.push_back(CH_CR);
         msg_bytes.push_back(CH_LF);
      end
      msg_bytes.push_back(CH_CR);
      msg_bytes.push_back(CH_LF);
      repeat ($urandom_range(4)) msg_bytes.push_back(DataWidth'($urandom_range(255)));
   endtask

   initial begin : stimulus
      flaw_type flaw;
      int       roll;
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.data_byte        = '0;
      req_chan.first_of_message = 1'b0;
      words_sent                = 0;
      tx_idle_pct               = 15;
      rx_idle_pct               = 80;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty method and path, one header, blank line, body bytes at the extremes
      msg_bytes = '{CH_SP, CH_SP, CH_H, CH_T, CH_T, CH_P, CH_SLASH, 8'h31, CH_DOT, 8'h31,
                    CH_CR, CH_LF, 8'h41, CH_COLON, CH_CR, CH_LF, CH_CR, CH_LF, 8'hFF, 8'h00};
      send_message(1'b1, 1'b0);
      // short version, then a byte while frozen in error
      msg_bytes = '{CH_SP, CH_SP, CH_H, CH_CR, 8'hFF};
      send_message(1'b1, 1'b0);

      while (words_sent < WordTarget) begin
         if (words_sent < WordTarget / 3) begin
            tx_idle_pct = 15;
            rx_idle_pct = 80;
         end else if (words_sent < 2 * WordTarget / 3) begin
            tx_idle_pct = 80;
            rx_idle_pct = 15;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         roll = $urandom_range(99);
         if (roll < 55) flaw = FLAW_NONE;
         else if (roll < 67) flaw = FLAW_SWAP_BYTE;
         else if (roll < 75) flaw = FLAW_DROP_BYTE;
         else if (roll < 81) flaw = FLAW_NO_HEADER;
         else if (roll < 87) flaw = FLAW_SHORT_VERSION;
         else flaw = FLAW_NOISE;
         case (flaw)
            FLAW_NO_HEADER: compose_request(0, 8);
            FLAW_SHORT_VERSION: compose_request($urandom_range(1) + 1, $urandom_range(7));
            default: compose_request($urandom_range(1) + 1, 8);
         endcase
         if (flaw == FLAW_SWAP_BYTE) begin
            msg_bytes[$urandom_range(msg_bytes.size() - 1)] = DataWidth'($urandom_range(255));
         end else if (flaw == FLAW_DROP_BYTE) begin
            msg_bytes.delete($urandom_range(msg_bytes.size() - 1));
         end else if (flaw == FLAW_NOISE) begin
            msg_bytes.delete();
            repeat ($urandom_range(11) + 1)
               msg_bytes.push_back(DataWidth'($urandom_range(255)));
         end
         send_message($urandom_range(9) != 0, 1'b1);
      end
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_http_request_head_lexer passed");
      end else begin
         $display("tb_http_request_head_lexer failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/hrhl_pkg.sv
sv/hrhl_req_if.sv
sv/hrhl_rsp_if.sv
sv/hrhl_input_stage.sv
sv/hrhl_lexer_core.sv
sv/hrhl_result_stage.sv
sv/http_request_head_lexer.sv
tb/tb_hrhl_tag_checker.sv
tb/tb_http_request_head_lexer.sv
